// File: rtl/tbcl_pkg.sv
// package for the two-button combination lock
// holds event codes, register indexes and the config and result structs
// no dependencies
package tbcl_pkg;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_PRESS    = 3'd1,
        EV_LOCKED   = 3'd2,
        EV_UNLOCKED = 3'd3,
        EV_WRONG    = 3'd4,
        EV_TIMEOUT  = 3'd5
    } t_event;

    localparam logic [1:0] REG_CODE_LENGTH   = 2'd0;
    localparam logic [1:0] REG_ENTRY_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_SLEEP_AFTER   = 2'd2;

    localparam logic [3:0] RST_CODE_LENGTH   = 4'd6;
    localparam logic [7:0] RST_ENTRY_TIMEOUT = 8'd11;
    localparam logic [7:0] RST_SLEEP_AFTER   = 8'd34;

    localparam logic [7:0] TICK_MAX = 8'hff;

    typedef struct packed {
        logic [3:0] code_length;
        logic [7:0] entry_timeout;
        logic [7:0] sleep_after;
    } t_cfg;

    typedef struct packed {
        logic       is_locked;
        t_event     event_res;
        logic       display_on;
        logic [3:0] presses_entered;
    } t_result;

endpackage

// File: rtl/two_button_combination_lock.sv
// two-button combination lock: one request per cycle while the result queue is not full
// results are registered in the queue; throughput is set by the single state update pass
// a two-entry result queue keeps requests flowing while one result waits
// synchronous active-low reset: unlocked, counters and history cleared, registers at defaults
// depends on tbcl_pkg, tbcl_cfg, tbcl_core, tbcl_outq
module two_button_combination_lock
    import tbcl_pkg::*;
#(
    parameter int DEBOUNCE_SAMPLES = 6,
    parameter int MAX_CODE_BITS    = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_item_kind,
    input  logic        i_left_pressed,
    input  logic        i_right_pressed,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_is_locked,
    output logic [2:0]  o_event_res,
    output logic        o_display_on,
    output logic [3:0]  o_presses_entered,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg    cfg;
    t_result res;
    t_result q_data;
    logic    q_full;
    logic    accept;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    tbcl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tbcl_core #(
        .DEBOUNCE_SAMPLES (DEBOUNCE_SAMPLES),
        .MAX_CODE_BITS    (MAX_CODE_BITS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_item_kind     (i_item_kind),
        .i_left_pressed  (i_left_pressed),
        .i_right_pressed (i_right_pressed),
        .i_cfg           (cfg),
        .o_result        (res)
    );

    tbcl_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (res),
        .o_full  (q_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (q_data)
    );

    assign o_is_locked       = q_data.is_locked;
    assign o_event_res       = q_data.event_res;
    assign o_display_on      = q_data.display_on;
    assign o_presses_entered = q_data.presses_entered;

endmodule

// File: rtl/tbcl_cfg.sv
// apb-style configuration registers of the combination lock
// depends on tbcl_pkg
module tbcl_cfg
    import tbcl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [3:0] r_code_length;
    logic [7:0] r_entry_timeout;
    logic [7:0] r_sleep_after;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_length   <= RST_CODE_LENGTH;
            r_entry_timeout <= RST_ENTRY_TIMEOUT;
            r_sleep_after   <= RST_SLEEP_AFTER;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_CODE_LENGTH:   r_code_length   <= pwdata[3:0];
                REG_ENTRY_TIMEOUT: r_entry_timeout <= pwdata[7:0];
                REG_SLEEP_AFTER:   r_sleep_after   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_CODE_LENGTH:   prdata = {28'd0, r_code_length};
            REG_ENTRY_TIMEOUT: prdata = {24'd0, r_entry_timeout};
            REG_SLEEP_AFTER:   prdata = {24'd0, r_sleep_after};
            default:           prdata = 32'd0;
        endcase
    end

    assign o_cfg = '{code_length:   r_code_length,
                     entry_timeout: r_entry_timeout,
                     sleep_after:   r_sleep_after};

endmodule

// File: rtl/tbcl_core.sv
// lock state: debounce, code entry, compare, tick timers
// updates state on each accepted request and forms its result
// depends on tbcl_pkg
module tbcl_core
    import tbcl_pkg::*;
#(
    parameter int DEBOUNCE_SAMPLES = 6,
    parameter int MAX_CODE_BITS    = 8
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  logic    i_item_kind,
    input  logic    i_left_pressed,
    input  logic    i_right_pressed,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    localparam int D = DEBOUNCE_SAMPLES;
    localparam int M = MAX_CODE_BITS;
    localparam logic [4:0] MAX_LEN = 5'(MAX_CODE_BITS);

    logic [D-1:0] r_hist,    n_hist;
    logic         r_key,     n_key;
    logic         r_handled, n_handled;
    logic         r_last,    n_last;
    logic [3:0]   r_count,   n_count;
    logic [M-1:0] r_stored,  n_stored;
    logic [M-1:0] r_entered, n_entered;
    logic [7:0]   r_tick,    n_tick;
    logic         r_locked,  n_locked;

    logic [3:0]   len;
    logic [3:0]   cnt1;
    logic [M-1:0] ent;
    logic [7:0]   tick;
    t_event       evt;

    always_comb begin
        if (i_cfg.code_length == 4'd0) begin
            len = 4'd1;
        end else if ({1'b0, i_cfg.code_length} > MAX_LEN) begin
            len = MAX_LEN[3:0];
        end else begin
            len = i_cfg.code_length;
        end
    end

    always_comb begin
        n_hist    = r_hist;
        n_key     = r_key;
        n_handled = r_handled;
        n_last    = r_last;
        n_count   = r_count;
        n_stored  = r_stored;
        n_entered = r_entered;
        n_tick    = r_tick;
        n_locked  = r_locked;
        evt       = EV_NONE;
        cnt1      = r_count + 4'd1;
        ent       = M'({r_entered, n_last});
        tick      = r_tick;
        if (i_accept) begin
            if (!i_item_kind) begin
                n_hist = D'((r_hist << 1) | D'(i_left_pressed | i_right_pressed));
                if (i_left_pressed)  n_last = 1'b0;
                if (i_right_pressed) n_last = 1'b1;
                ent = M'({r_entered, n_last});
                if (n_hist == '1) n_key = 1'b1;
                if (n_hist == '0) n_key = 1'b0;
                if (n_key) begin
                    if (!r_handled) begin
                        n_handled = 1'b1;
                        n_tick    = 8'd0;
                        if (r_count < len) begin
                            if (!r_locked) begin
                                n_stored = M'({r_stored, n_last});
                                if (cnt1 == len) begin
                                    n_locked  = 1'b1;
                                    n_count   = 4'd0;
                                    n_entered = '0;
                                    evt       = EV_LOCKED;
                                end else begin
                                    n_count = cnt1;
                                    evt     = EV_PRESS;
                                end
                            end else if (cnt1 == len) begin
                                n_count   = 4'd0;
                                n_entered = '0;
                                if (ent == r_stored) begin
                                    n_stored = '0;
                                    n_locked = 1'b0;
                                    evt      = EV_UNLOCKED;
                                end else begin
                                    evt = EV_WRONG;
                                end
                            end else begin
                                n_entered = ent;
                                n_count   = cnt1;
                                evt       = EV_PRESS;
                            end
                        end
                    end
                end else begin
                    n_handled = 1'b0;
                end
            end else begin
                if (r_tick <= i_cfg.sleep_after && r_tick != TICK_MAX) begin
                    tick = r_tick + 8'd1;
                end
                if (tick > i_cfg.entry_timeout && r_count != 4'd0) begin
                    if (!r_locked) n_stored = '0;
                    n_entered = '0;
                    n_count   = 4'd0;
                    tick      = 8'd0;
                    evt       = EV_TIMEOUT;
                end
                n_tick = tick;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist    <= '0;
            r_key     <= 1'b0;
            r_handled <= 1'b0;
            r_last    <= 1'b0;
            r_count   <= 4'd0;
            r_stored  <= '0;
            r_entered <= '0;
            r_tick    <= 8'd0;
            r_locked  <= 1'b0;
        end else begin
            r_hist    <= n_hist;
            r_key     <= n_key;
            r_handled <= n_handled;
            r_last    <= n_last;
            r_count   <= n_count;
            r_stored  <= n_stored;
            r_entered <= n_entered;
            r_tick    <= n_tick;
            r_locked  <= n_locked;
        end
    end

    assign o_result = '{is_locked:       n_locked,
                        event_res:       evt,
                        display_on:      (n_tick < i_cfg.sleep_after),
                        presses_entered: n_count};

endmodule

// File: rtl/tbcl_outq.sv
// two-entry result queue between the lock state and the output port
// depends on tbcl_pkg
module tbcl_outq
    import tbcl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_data
);

    t_result    r_data [2];
    logic       r_head;
    logic [1:0] r_count;
    logic       pop;
    logic       wr_idx;

    assign pop    = o_valid && !i_stall;
    assign wr_idx = r_head ^ r_count[0];
    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_data[r_head];

    always_ff @(posedge i_clk) begin
        if (i_push) r_data[wr_idx] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (pop) r_head <= !r_head;
            r_count <= r_count + 2'(i_push) - 2'(pop);
        end
    end

endmodule

// File: sim/lock_checker.sv
// result checker for the two-button combination lock: follows register writes,
// predicts one result per accepted request and compares results in order
// depends on tbcl_pkg
module lock_checker
    import tbcl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_item_kind,
    input  logic        i_left_pressed,
    input  logic        i_right_pressed,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_is_locked,
    input  logic [2:0]  i_event_res,
    input  logic        i_display_on,
    input  logic [3:0]  i_presses_entered,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [5:0] HISTORY_FULL = 6'b111111;
    localparam logic [3:0] CODE_MAX     = 4'd8;

    t_cfg       cfg;
    logic [5:0] history;
    logic       key_down;
    logic       press_taken;
    logic       last_right;
    logic [3:0] press_count;
    logic [7:0] stored_code;
    logic [7:0] entered_code;
    logic [7:0] tick_count;
    logic       locked;
    t_result    expected_results[$];

    task automatic advance_lock(input logic is_tick, input logic left, input logic right,
                                output t_result res);
        logic [3:0] len;
        t_event     ev;
        len = (cfg.code_length == 4'd0) ? 4'd1 :
              (cfg.code_length > CODE_MAX) ? CODE_MAX : cfg.code_length;
        ev = EV_NONE;
        if (!is_tick) begin
            history = {history[4:0], left | right};
            if (left) last_right = 1'b0;
            if (right) last_right = 1'b1;
            if (history == HISTORY_FULL) key_down = 1'b1;
            if (history == '0) key_down = 1'b0;
            if (!key_down) begin
                press_taken = 1'b0;
            end else if (!press_taken) begin
                press_taken = 1'b1;
                tick_count = '0;
                if (press_count < len) begin
                    press_count = press_count + 4'd1;
                    if (!locked) begin
                        stored_code = {stored_code[6:0], last_right};
                        if (press_count == len) begin
                            locked = 1'b1;
                            press_count = '0;
                            entered_code = '0;
                            ev = EV_LOCKED;
                        end else begin
                            ev = EV_PRESS;
                        end
                    end else begin
                        entered_code = {entered_code[6:0], last_right};
                        if (press_count != len) begin
                            ev = EV_PRESS;
                        end else if (entered_code == stored_code) begin
                            press_count = '0;
                            entered_code = '0;
                            stored_code = '0;
                            locked = 1'b0;
                            ev = EV_UNLOCKED;
                        end else begin
                            press_count = '0;
                            entered_code = '0;
                            ev = EV_WRONG;
                        end
                    end
                end
            end
        end else begin
            if (tick_count <= cfg.sleep_after && tick_count != TICK_MAX)
                tick_count = tick_count + 8'd1;
            if (tick_count > cfg.entry_timeout && press_count != 0) begin
                if (!locked) stored_code = '0;
                entered_code = '0;
                press_count = '0;
                tick_count = '0;
                ev = EV_TIMEOUT;
            end
        end
        res.is_locked = locked;
        res.event_res = ev;
        res.display_on = (tick_count < cfg.sleep_after);
        res.presses_entered = press_count;
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            cfg.code_length = RST_CODE_LENGTH;
            cfg.entry_timeout = RST_ENTRY_TIMEOUT;
            cfg.sleep_after = RST_SLEEP_AFTER;
            history = '0;
            key_down = 1'b0;
            press_taken = 1'b0;
            last_right = 1'b0;
            press_count = '0;
            stored_code = '0;
            entered_code = '0;
            tick_count = '0;
            locked = 1'b0;
            expected_results.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_CODE_LENGTH:   cfg.code_length = pwdata[3:0];
                    REG_ENTRY_TIMEOUT: cfg.entry_timeout = pwdata[7:0];
                    REG_SLEEP_AFTER:   cfg.sleep_after = pwdata[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                advance_lock(i_item_kind, i_left_pressed, i_right_pressed, want);
                expected_results.push_back(want);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding");
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_is_locked !== want.is_locked) begin
                        $error("is_locked: expected %0d, actual %0d",
                               want.is_locked, i_is_locked);
                        o_fail_count++;
                    end
                    if (i_event_res !== want.event_res) begin
                        $error("event_res: expected %0d, actual %0d",
                               want.event_res, i_event_res);
                        o_fail_count++;
                    end
                    if (i_display_on !== want.display_on) begin
                        $error("display_on: expected %0d, actual %0d",
                               want.display_on, i_display_on);
                        o_fail_count++;
                    end
                    if (i_presses_entered !== want.presses_entered) begin
                        $error("presses_entered: expected %0d, actual %0d",
                               want.presses_entered, i_presses_entered);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// File: sim/tb_top.sv
// testbench top for the two-button combination lock: drives button samples,
// ticks and register writes, and reports the verdict from lock_checker
// depends on tbcl_pkg, lock_checker and the lock rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tbcl_pkg::*;

    localparam logic KIND_BUTTON = 1'b0;
    localparam logic KIND_TICK   = 1'b1;
    localparam int   RANDOM_REQS = 700;
    localparam int   HOLD_CYCLES = 60;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_item_kind;
    logic        i_left_pressed;
    logic        i_right_pressed;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_is_locked;
    logic [2:0]  o_event_res;
    logic        o_display_on;
    logic [3:0]  o_presses_entered;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int         fail_count;
    int         pending;
    int         sent;
    bit         calm;
    bit         hold_req;
    bit         guess_locked;
    logic [7:0] guess_code;
    logic [3:0] cur_len;
    logic [7:0] cur_timeout;
    logic [7:0] cur_sleep;

    two_button_combination_lock dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_item_kind(i_item_kind), .i_left_pressed(i_left_pressed),
        .i_right_pressed(i_right_pressed),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_is_locked(o_is_locked), .o_event_res(o_event_res),
        .o_display_on(o_display_on), .o_presses_entered(o_presses_entered),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    lock_checker result_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_item_kind(i_item_kind), .i_left_pressed(i_left_pressed),
        .i_right_pressed(i_right_pressed),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_is_locked(o_is_locked), .i_event_res(o_event_res),
        .i_display_on(o_display_on), .i_presses_entered(o_presses_entered),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // receiver side: random stalls, one long hold-off on request
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end
            i_out_stall <= !calm && ($urandom_range(99) < 7);
        end
    end

    task automatic send_req(input logic kind, input logic left, input logic right);
        i_in_valid <= 1'b1;
        i_item_kind <= kind;
        i_left_pressed <= left;
        i_right_pressed <= right;
        do @(posedge i_clk); while (o_in_stall);
        sent++;
        @(negedge i_clk);
        if (!calm && $urandom_range(99) < 7) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
    endtask

    task automatic go_idle();
        i_in_valid <= 1'b0;
        wait (pending == 0);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input logic [3:0] len, input logic [7:0] timeout,
                              input logic [7:0] sleep);
        go_idle();
        write_reg(REG_CODE_LENGTH, {28'd0, len});
        write_reg(REG_ENTRY_TIMEOUT, {24'd0, timeout});
        write_reg(REG_SLEEP_AFTER, {24'd0, sleep});
        cur_len = len;
        cur_timeout = timeout;
        cur_sleep = sleep;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_req(KIND_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    task automatic release_key(input int n);
        repeat (n) send_req(KIND_BUTTON, 1'b0, 1'b0);
    endtask

    task automatic press_key(input logic left, input logic right, input int hold);
        repeat (hold) send_req(KIND_BUTTON, left, right);
        release_key($urandom_range(6, 8));
    endtask

    // msb of the code is pressed first
    task automatic enter_code(input logic [7:0] code, input int n);
        for (int i = n - 1; i >= 0; i--) begin
            if (i != n - 1 && $urandom_range(9) < 3)
                send_ticks($urandom_range(0, (cur_timeout < 3) ? cur_timeout : 3));
            if ($urandom_range(99) < 15) begin
                repeat ($urandom_range(1, 5)) send_req(KIND_BUTTON, !code[i], code[i]);
                release_key(6);
            end
            press_key(code[i] ? 1'($urandom_range(4) == 0) : 1'b1, code[i],
                      ($urandom_range(9) == 0) ? $urandom_range(10, 20) : $urandom_range(6, 8));
        end
    endtask

    function automatic logic [7:0] pick_limit();
        case ($urandom_range(9))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd254;
            3, 4, 5: return 8'($urandom_range(1, 8));
            default: return 8'($urandom_range(9, 40));
        endcase
    endfunction

    initial begin
        int          phase;
        int          phase_end;
        int          random_start;
        int          n;
        int          roll;
        logic [3:0]  len;
        logic [7:0]  code;
        logic [8:0]  span;

        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_item_kind = 1'b0;
        i_left_pressed = 1'b0;
        i_right_pressed = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        calm = 1'b0;
        hold_req = 1'b0;
        sent = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero length acts as one press; both buttons count as right
        set_config(4'd0, 8'd11, 8'd34);
        send_ticks(1);
        press_key(1'b0, 1'b1, 6);
        press_key(1'b1, 1'b0, 6);
        press_key(1'b0, 1'b1, 6);
        press_key(1'b1, 1'b1, 6);
        press_key(1'b1, 1'b1, 6);

        // oversized length acts as eight, held key and a short bounce
        set_config(4'd15, 8'd11, 8'd34);
        press_key(1'b1, 1'b0, 20);
        repeat (5) send_req(KIND_BUTTON, 1'b0, 1'b1);
        release_key(6);
        enter_code(8'b00000101, 7);

        // timeout while locked keeps the combination
        set_config(4'd15, 8'd0, 8'd255);
        press_key(1'b0, 1'b1, 6);
        send_ticks(1);
        set_config(4'd3, 8'd11, 8'd34);
        enter_code(8'd5, 3);

        // press with the count already full, then timeout while unlocked
        set_config(4'd6, 8'd11, 8'd34);
        enter_code(8'ha, 4);
        set_config(4'd2, 8'd0, 8'd255);
        press_key(1'b0, 1'b1, 6);
        send_ticks(1);

        // display asleep at once, then tick count saturating
        set_config(4'd6, 8'd11, 8'd0);
        send_ticks(2);
        set_config(4'd6, 8'd255, 8'd255);
        send_ticks(260);

        guess_locked = 1'b0;
        guess_code = '0;
        phase = 0;
        random_start = sent;
        while (sent - random_start < RANDOM_REQS) begin
            case ($urandom_range(9))
                0: len = 4'd0;
                1: len = 4'd15;
                2: len = 4'd1;
                3: len = 4'd8;
                default: len = 4'($urandom_range(1, 8));
            endcase
            set_config(len, pick_limit(), pick_limit());
            n = (cur_len == 4'd0) ? 1 : (cur_len > 4'd8) ? 8 : cur_len;
            span = 9'd1 << n;
            calm = (phase == 1);
            if (phase == 0) hold_req = 1'b1;
            phase_end = sent + $urandom_range(100, 200);
            while (sent < phase_end) begin
                roll = $urandom_range(99);
                if (roll < 10) begin
                    repeat ($urandom_range(1, 5))
                        send_req(KIND_BUTTON, 1'($urandom_range(1)), 1'($urandom_range(1)));
                    release_key(6);
                end else if (roll < 20 && n > 1 && cur_timeout <= cur_sleep &&
                             cur_timeout <= 8'd40) begin
                    // abandoned entry, cleared by the timeout
                    enter_code(8'($urandom_range(255)), $urandom_range(1, n - 1));
                    send_ticks(cur_timeout + 1);
                end else begin
                    if (guess_locked && guess_code < span && $urandom_range(9) < 7)
                        code = guess_code;
                    else
                        code = 8'($urandom_range(255)) & 8'(span - 9'd1);
                    enter_code(code, n);
                    if (!guess_locked) begin
                        guess_locked = 1'b1;
                        guess_code = code;
                    end else if (code == guess_code) begin
                        guess_locked = 1'b0;
                    end
                end
                if ($urandom_range(9) < 2) send_ticks($urandom_range(0, 40));
            end
            calm = 1'b0;
            phase++;
        end

        go_idle();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
